/* src/u8u16_pkg.sv */
package u8u16_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_replacement;
      logic        run_last;
      logic        string_last;
   } rsp_type;

   typedef enum logic [2:0] {
      CLASS_CONT  = 3'd0,
      CLASS_ASCII = 3'd1,
      CLASS_LEAD2 = 3'd2,
      CLASS_LEAD3 = 3'd3,
      CLASS_LEAD4 = 3'd4,
      CLASS_BAD   = 3'd5
   } byte_kind_type;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_UNIT = 2'd1,
      TAIL_PAIR = 2'd2
   } tail_type;

   typedef struct packed {
      logic [2:0]  qcount;
      tail_type    tail;
      logic [15:0] unit_first;
      logic [15:0] unit_second;
      logic        end_of_string;
   } job_type;

   localparam logic [15:0] UNIT_QMARK = 16'h003F;
   localparam logic [15:0] HI_SURR    = 16'hD800;
   localparam logic [5:0]  LO_SURR_HI = 6'b110111;
   localparam logic [20:0] SUPP_BASE  = 21'h010000;

   function automatic byte_kind_type classify_byte(input logic [7:0] b);
      byte_kind_type c;
      priority if (b[7] == 1'b0) c = CLASS_ASCII;
      else if (b[7:6] == 2'b10) c = CLASS_CONT;
      else if (b[7:5] == 3'b110) c = CLASS_LEAD2;
      else if (b[7:4] == 4'b1110) c = CLASS_LEAD3;
      else if (b[7:3] == 5'b11110) c = CLASS_LEAD4;
      else c = CLASS_BAD;
      return c;
   endfunction

endpackage

/* src/u8u16_front.sv */
module u8u16_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  u8u16_pkg::req_type   req_data,
   input  logic                 fifo_full,
   output logic                 push,
   output u8u16_pkg::job_type   job
);

   logic [1:0]  count_ff, count_in;
   logic [2:0]  length_ff, length_in;
   logic [14:0] acc_ff, acc_in;

   u8u16_pkg::byte_kind_type cls;
   logic        accept;
   logic        is_end;
   logic [7:0]  b;
   logic        judge_q;
   logic        judge_hold;
   logic        judge_unit;
   logic [14:0] lead_bits;
   logic [20:0] cp;
   logic [20:0] v;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;
   assign b         = req_data.data_byte;
   assign is_end    = req_data.end_of_string;
   assign cls       = u8u16_pkg::classify_byte(b);
   assign cp        = {acc_ff, b[5:0]};
   assign v         = cp - u8u16_pkg::SUPP_BASE;

   always_comb begin
      judge_q    = 1'b0;
      judge_hold = 1'b0;
      judge_unit = 1'b0;
      lead_bits  = '0;
      unique case (cls)
         u8u16_pkg::CLASS_ASCII: judge_unit = 1'b1;
         u8u16_pkg::CLASS_LEAD2: begin
            judge_q    = is_end;
            judge_hold = !is_end;
            lead_bits  = {10'd0, b[4:0]};
         end
         u8u16_pkg::CLASS_LEAD3: begin
            judge_q    = is_end;
            judge_hold = !is_end;
            lead_bits  = {11'd0, b[3:0]};
         end
         u8u16_pkg::CLASS_LEAD4: begin
            judge_q    = is_end;
            judge_hold = !is_end;
            lead_bits  = {12'd0, b[2:0]};
         end
         default: judge_q = 1'b1;
      endcase
   end

   always_comb begin
      job               = '0;
      job.end_of_string = is_end;
      job.tail          = u8u16_pkg::TAIL_NONE;
      count_in          = count_ff;
      length_in         = length_ff;
      acc_in            = acc_ff;
      if (count_ff == 2'd0 || cls != u8u16_pkg::CLASS_CONT) begin
         // flush held bytes as '?', then judge the new byte as a lead
         job.qcount     = {1'b0, count_ff} + {2'd0, judge_q};
         job.unit_first = {8'd0, b};
         if (judge_unit) begin
            job.tail = u8u16_pkg::TAIL_UNIT;
         end
         if (judge_hold) begin
            count_in  = 2'd1;
            length_in = cls;
            acc_in    = lead_bits;
         end else begin
            count_in  = 2'd0;
            length_in = 3'd0;
         end
      end else if ({1'b0, count_ff} + 3'd1 == length_ff) begin
         count_in  = 2'd0;
         length_in = 3'd0;
         if (cp[20:16] == 5'd0) begin
            job.tail       = u8u16_pkg::TAIL_UNIT;
            job.unit_first = cp[15:0];
         end else begin
            job.tail        = u8u16_pkg::TAIL_PAIR;
            job.unit_first  = u8u16_pkg::HI_SURR + {5'd0, v[20:10]};
            job.unit_second = {u8u16_pkg::LO_SURR_HI, cp[9:0]};
         end
      end else if (is_end || count_ff == 2'd3) begin
         job.qcount = {1'b0, count_ff} + 3'd1;
         count_in   = 2'd0;
         length_in  = 3'd0;
      end else begin
         acc_in   = {acc_ff[8:0], b[5:0]};
         count_in = count_ff + 2'd1;
      end
   end

   assign push = accept && (job.qcount != 3'd0 || job.tail != u8u16_pkg::TAIL_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         length_ff <= 3'd0;
      end else if (accept) begin
         count_ff  <= count_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* src/u8u16_fifo.sv */
module u8u16_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u8u16_pkg::job_type   push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output u8u16_pkg::job_type   head_job
);

   localparam int Depth = 2;
   localparam int AddrW = $clog2(Depth);

   u8u16_pkg::job_type entries_ff [Depth];
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AddrW:0]   count_ff, count_in;

   assign full       = count_ff == (AddrW+1)'(Depth);
   assign head_valid = count_ff != '0;
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* src/u8u16_back.sv */
module u8u16_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  u8u16_pkg::job_type   head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output u8u16_pkg::rsp_type   rsp_data
);

   logic [1:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   u8u16_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       load;
   logic       last;
   logic [2:0] idx;
   logic [2:0] tail_n;
   logic [2:0] total;

   assign idx  = {1'b0, step_ff};
   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      unique case (head_job.tail)
         u8u16_pkg::TAIL_UNIT: tail_n = 3'd1;
         u8u16_pkg::TAIL_PAIR: tail_n = 3'd2;
         default:              tail_n = 3'd0;
      endcase
   end

   assign total = head_job.qcount + tail_n;
   assign last  = (idx + 3'd1) == total;
   assign pop   = load && last;

   always_comb begin
      rsp_data_in.run_last    = last;
      rsp_data_in.string_last = last && head_job.end_of_string;
      priority if (idx < head_job.qcount) begin
         rsp_data_in.code_unit      = u8u16_pkg::UNIT_QMARK;
         rsp_data_in.is_replacement = 1'b1;
      end else if (idx == head_job.qcount) begin
         rsp_data_in.code_unit      = head_job.unit_first;
         rsp_data_in.is_replacement = 1'b0;
      end else begin
         rsp_data_in.code_unit      = head_job.unit_second;
         rsp_data_in.is_replacement = 1'b0;
      end
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         step_in      = last ? 2'd0 : step_ff + 2'd1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/utf8_to_utf16_transcoder.sv */
// UTF-8 to UTF-16 transcoder.
// req_ channel: one byte of a UTF-8 string per transfer, end_of_string set
// on the final byte. rsp_ channel: UTF-16 code units, one per transfer, with
// is_replacement on '?' units for undecodable bytes, run_last on the last
// unit a byte causes and string_last on the final unit of the string.
// A front stage classifies each byte, assembles multi-byte sequences and
// hands a job (0 to 4 '?' units, then possibly a unit or a surrogate pair)
// to a two-entry queue; a back stage expands each job, one unit per cycle
// while rsp_stall is low, into the output register. Each unit is held in
// a queue entry and then in the output register before it reaches rsp_.
// Throughput: one byte per cycle while rsp_stall is low and each byte yields
// at most one unit; a byte yielding more units occupies the back stage until
// its last unit is loaded. req_stall rises only when the queue is full.
// While rsp_stall is high the output holds and the queue fills, then
// req_stall rises. Reset clears the held sequence, the queue and rsp_valid.
module utf8_to_utf16_transcoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  u8u16_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u8u16_pkg::rsp_type rsp_data
);

   logic               push;
   logic               pop;
   logic               full;
   logic               head_valid;
   u8u16_pkg::job_type push_job;
   u8u16_pkg::job_type head_job;

   u8u16_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fifo_full (full),
      .push      (push),
      .job       (push_job)
   );

   u8u16_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u8u16_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* src/u8u16_checker.sv */
module u8u16_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input u8u16_pkg::rsp_type rsp_data
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transfer dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_last |-> rsp_data.run_last)
      else $error("string_last without run_last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_replacement |-> rsp_data.code_unit == u8u16_pkg::UNIT_QMARK)
      else $error("replacement unit is not '?'");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);
